// ===== rtl/core/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII core.
// No dependencies.
package sitda_pkg;

    localparam int unsigned OUT_LIMIT = 20;   // most characters per request
    localparam int unsigned NDIG_MAX  = 10;   // most digits of a 32-bit magnitude

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit x
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;

    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_MINUS = 7'h2D;
    localparam logic [6:0] ASCII_SPACE = 7'h20;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIG  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii_core.sv =====
// Signed 32-bit integer to right-justified decimal ASCII text.
// Uses sitda_pkg.
//
// Input channel (i_in_valid / o_in_stall) takes a value and a minimum width.
// Output channel (o_out_valid / i_out_stall) gives a request's characters in turn,
// most significant first, o_last high on the final one. Spaces pad on the
// left up to min_width (clamped to MAX_LEN, output capped at 20 characters),
// then '-' for negative values, then the digits.
// Steps: take the request, then per digit a multiply and a quotient/remainder
// step on the shared reciprocal multiplier, then one character per cycle while
// the receiver does not stall. The input is stalled from acceptance until the
// last character is loaded into the output register; the next request is taken
// while that final character still waits.
// A stalled output holds its character and pauses the emit counter.
// Reset (synchronous, active low) returns to idle with no output pending.
module signed_int_to_decimal_ascii_core #(
    parameter int MAX_LEN = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value,
    input  logic [4:0]  i_min_width,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_character,
    output logic        o_last
);
    import sitda_pkg::*;

    localparam logic [6:0] MaxLenW = 7'(MAX_LEN);
    localparam logic [6:0] OutLimW = 7'(OUT_LIMIT);
    localparam logic [3:0] NdigMaxW = 4'(NDIG_MAX);

    t_state      r_state, n_state;
    logic        r_neg, n_neg;
    logic [31:0] r_mag, n_mag;
    logic [4:0]  r_width, n_width;
    logic [63:0] r_prod, n_prod;
    logic [3:0]  r_ndig, n_ndig;
    logic [4:0]  r_total, n_total;
    logic [4:0]  r_pad, n_pad;
    logic [4:0]  r_pos, n_pos;
    logic        r_out_valid, n_out_valid;
    logic [6:0]  r_char, n_char;
    logic        r_last, n_last;
    logic [3:0]  r_digits [NDIG_MAX];

    logic [28:0] quot;
    logic [3:0]  rem;
    logic [3:0]  ndig_inc;
    logic [6:0]  textlen;
    logic [6:0]  width_sat;
    logic [6:0]  total_w;
    logic [4:0]  dig_idx;
    logic        load;

    assign quot     = r_prod[DIV10_SHIFT +: 29];
    // remainder < 10, so the low nibble of mag - 10*q is exact
    assign rem      = r_mag[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
    assign ndig_inc = r_ndig + 4'd1;
    assign textlen  = {3'b000, ndig_inc} + {6'd0, r_neg};
    assign dig_idx  = r_total - 5'd1 - r_pos;
    assign load     = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        width_sat = {2'b00, r_width};
        if (width_sat > MaxLenW) begin
            width_sat = MaxLenW;
        end
        total_w = (width_sat > textlen) ? width_sat : textlen;
        if (total_w > OutLimW) begin
            total_w = OutLimW;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_width     = r_width;
        n_prod      = r_prod;
        n_ndig      = r_ndig;
        n_total     = r_total;
        n_pad       = r_pad;
        n_pos       = r_pos;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_neg   = i_value[31];
                    n_mag   = i_value[31] ? (32'd0 - i_value) : i_value;
                    n_width = i_min_width;
                    n_ndig  = 4'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = r_mag * DIV10_RECIP;
                n_state = S_DIG;
            end
            S_DIG: begin
                n_mag  = {3'b000, quot};
                n_ndig = ndig_inc;
                if (quot == 29'd0 || ndig_inc == NdigMaxW) begin
                    n_total = total_w[4:0];
                    n_pad   = total_w[4:0] - textlen[4:0];
                    n_pos   = 5'd0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    if (r_pos < r_pad) begin
                        n_char = ASCII_SPACE;
                    end else if (r_neg && r_pos == r_pad) begin
                        n_char = ASCII_MINUS;
                    end else begin
                        n_char = ASCII_ZERO + {3'b000, r_digits[dig_idx[3:0]]};
                    end
                    n_last = (r_pos == r_total - 5'd1);
                    n_pos  = r_pos + 5'd1;
                    if (r_pos == r_total - 5'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_width <= n_width;
        r_prod  <= n_prod;
        r_ndig  <= n_ndig;
        r_total <= n_total;
        r_pad   <= n_pad;
        r_pos   <= n_pos;
        r_char  <= n_char;
        r_last  <= n_last;
        if (r_state == S_DIG) begin
            r_digits[r_ndig] <= rem;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
